// ===== rtl/ssd_pkg.sv =====
// Shared types, codes and constants of the seven-segment scan driver.
// Used by ssd_ctrl, ssd_datapath and seven_segment_scan_driver_top; no dependencies.
`timescale 1ns / 1ps

package ssd_pkg;

  // Default parameter values
  localparam int MAX_DIGITS_DEF = 16;
  localparam int TIMER_BITS_DEF = 16;

  // Field widths
  localparam int OP_W       = 3;
  localparam int POS_W      = 4;
  localparam int CHAR_W     = 7;
  localparam int NUM_W      = 15;
  localparam int SEG_W      = 8;
  localparam int EN_W       = 16;
  localparam int PIN_MAP_W  = 24;
  localparam int COUNT_W    = 5;
  localparam int PERIOD_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_CHAR    = 3'd1;
  localparam logic [OP_W-1:0] OP_BLINK   = 3'd2;
  localparam logic [OP_W-1:0] OP_NUMBER  = 3'd3;
  localparam logic [OP_W-1:0] OP_SAVE    = 3'd4;
  localparam logic [OP_W-1:0] OP_RESTORE = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_MAP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRESH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD  = 3'd4;

  // Configuration reset values
  localparam logic [PIN_MAP_W-1:0] PIN_MAP_RST  = 24'd16434824;
  localparam logic [COUNT_W-1:0]   COUNT_RST    = 5'd4;
  localparam logic [PERIOD_W-1:0]  REFRESH_RST  = 16'd100;
  localparam logic [PERIOD_W-1:0]  BLINK_RST    = 16'd5000;

  // Divide by ten through the reciprocal 0xCCCD, shifted right by 19
  localparam logic [15:0] RECIP_TEN  = 16'hCCCD;
  localparam int          RECIP_SHFT = 19;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_code;
    logic              blink_flag;
    logic [NUM_W-1:0]  number;
  } in_item_t;

  typedef struct packed {
    logic [SEG_W-1:0] segments;
    logic [EN_W-1:0]  digit_enable;
    logic             blink_phase;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic start;
    logic conv_step;
    logic load_out;
  } ssd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic conv_last;
  } ssd_status_t;

  // Glyph table, segment a in the top bit, decimal point in the bottom bit
  function automatic logic [SEG_W-1:0] glyph_of(input logic [CHAR_W-1:0] c);
    logic [SEG_W-1:0] g;
    case (c)
      7'h30:   g = 8'b11111100;
      7'h31:   g = 8'b01100000;
      7'h32:   g = 8'b11011010;
      7'h33:   g = 8'b11110010;
      7'h34:   g = 8'b01100110;
      7'h35:   g = 8'b10110110;
      7'h36:   g = 8'b10111110;
      7'h37:   g = 8'b11100000;
      7'h38:   g = 8'b11111110;
      7'h39:   g = 8'b11110110;
      7'h2D:   g = 8'h02;
      7'h5F:   g = 8'h10;
      7'h60:   g = 8'h80;
      7'h2E:   g = 8'h01;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/ssd_ctrl.sv =====
// Controller of the seven-segment scan driver: request sequencing and output handshake.
// Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ssd_pkg::OP_W-1:0]    op,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ssd_pkg::ssd_cmd_t           cmd,
  input  ssd_pkg::ssd_status_t        status
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Sequence one request at a time
  always_comb begin
    state_next    = state;
    cmd.start     = 1'b0;
    cmd.conv_step = 1'b0;
    cmd.load_out  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = (op == ssd_pkg::OP_NUMBER) ? ST_CONV : ST_EMIT;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (status.conv_last) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Never overwrite a result that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_out && out_valid && out_stall))
    else $error("result overwritten while stalled");

  // A loaded result is offered next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not offered");

  // A number write goes to conversion
  a_number_conv: assert property (@(posedge clk) disable iff (rst)
    (accept && op == ssd_pkg::OP_NUMBER) |=> (state == ST_CONV))
    else $error("number write skipped conversion");

  // Any other request goes straight to the result
  a_other_emit: assert property (@(posedge clk) disable iff (rst)
    (accept && op != ssd_pkg::OP_NUMBER) |=> (state == ST_EMIT))
    else $error("request did not reach result stage");

endmodule

// ===== rtl/ssd_datapath.sv =====
// Datapath of the seven-segment scan driver: configuration, digit store, timers,
// decimal conversion and segment mapping. Depends on ssd_pkg.
`timescale 1ns / 1ps

module ssd_datapath #(
  parameter int MAX_DIGITS = ssd_pkg::MAX_DIGITS_DEF,
  parameter int TIMER_BITS = ssd_pkg::TIMER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write_enable,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  ssd_pkg::in_item_t                 in_item,
  output ssd_pkg::out_item_t                out_item,
  input  ssd_pkg::ssd_cmd_t                 cmd,
  output ssd_pkg::ssd_status_t              status
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CMP_W = (TIMER_BITS + 1 > ssd_pkg::PERIOD_W + 1) ?
                         TIMER_BITS + 1 : ssd_pkg::PERIOD_W + 1;
  localparam int Q_W   = ssd_pkg::NUM_W + 16 - ssd_pkg::RECIP_SHFT;

  // Configuration
  logic [ssd_pkg::PIN_MAP_W-1:0] pin_map;
  logic                          invert;
  logic [ssd_pkg::COUNT_W-1:0]   digit_count;
  logic [ssd_pkg::PERIOD_W-1:0]  refresh_period;
  logic [ssd_pkg::PERIOD_W-1:0]  blink_period;

  // Display state
  logic [ssd_pkg::CHAR_W-1:0] digit_chars [MAX_DIGITS];
  logic                       digit_blink [MAX_DIGITS];
  logic [ssd_pkg::CHAR_W-1:0] saved_chars [MAX_DIGITS];
  logic                       saved_blink [MAX_DIGITS];
  logic [ssd_pkg::POS_W-1:0]  scan_position;
  logic                       blink_state;
  logic [TIMER_BITS-1:0]      refresh_count;
  logic [TIMER_BITS-1:0]      blink_count;

  // Conversion
  logic [ssd_pkg::NUM_W-1:0] num_reg;
  logic [IDX_W-1:0]          conv_idx;

  logic [ssd_pkg::COUNT_W-1:0] count_eff;
  logic [IDX_W-1:0]            conv_first;
  logic                        pos_ok;
  logic [IDX_W-1:0]            pos_idx;
  logic [TIMER_BITS:0]         refresh_nx;
  logic [TIMER_BITS:0]         blink_nx;
  logic [ssd_pkg::PERIOD_W-1:0] refresh_eff;
  logic [ssd_pkg::PERIOD_W-1:0] blink_eff;
  logic                        refresh_hit;
  logic                        blink_hit;
  logic [ssd_pkg::COUNT_W-1:0] scan_nx;
  logic [30:0]                 prod;
  logic [Q_W-1:0]              quot;
  logic [ssd_pkg::NUM_W-1:0]   quot_ten;
  logic [3:0]                  rem;
  logic [IDX_W-1:0]            scan_idx;
  logic [ssd_pkg::SEG_W-1:0]   glyph;
  logic [ssd_pkg::SEG_W-1:0]   mapped;
  logic [ssd_pkg::EN_W-1:0]    onehot;
  ssd_pkg::out_item_t          display;

  function automatic logic [30:0] in_num_ext(input logic [ssd_pkg::NUM_W-1:0] v);
    return 31'(v);
  endfunction

  // Clamp digit count into one to MAX_DIGITS
  always_comb begin
    if (digit_count == '0) count_eff = ssd_pkg::COUNT_W'(1);
    else if (digit_count > ssd_pkg::COUNT_W'(MAX_DIGITS)) count_eff = ssd_pkg::COUNT_W'(MAX_DIGITS);
    else count_eff = digit_count;
  end

  assign conv_first = IDX_W'(count_eff - ssd_pkg::COUNT_W'(1));
  assign pos_ok     = ({1'b0, in_item.position} < ssd_pkg::COUNT_W'(MAX_DIGITS));
  assign pos_idx    = in_item.position[IDX_W-1:0];

  // Timers elapse at the period or on counter overflow
  assign refresh_eff = (refresh_period == '0) ? ssd_pkg::PERIOD_W'(1) : refresh_period;
  assign blink_eff   = (blink_period == '0) ? ssd_pkg::PERIOD_W'(1) : blink_period;
  assign refresh_nx  = {1'b0, refresh_count} + (TIMER_BITS + 1)'(1);
  assign blink_nx    = {1'b0, blink_count} + (TIMER_BITS + 1)'(1);
  assign refresh_hit = (CMP_W'(refresh_nx) >= CMP_W'(refresh_eff)) || refresh_nx[TIMER_BITS];
  assign blink_hit   = (CMP_W'(blink_nx) >= CMP_W'(blink_eff)) || blink_nx[TIMER_BITS];
  assign scan_nx     = {1'b0, scan_position} + ssd_pkg::COUNT_W'(1);

  // Divide by ten with the reciprocal, remainder by subtraction
  assign prod     = 31'(in_num_ext(num_reg) * ssd_pkg::RECIP_TEN);
  assign quot     = prod[30:ssd_pkg::RECIP_SHFT];
  assign quot_ten = ssd_pkg::NUM_W'({quot, 3'b000}) + ssd_pkg::NUM_W'({quot, 1'b0});
  assign rem      = 4'(num_reg - quot_ten);
  assign status.conv_last = (conv_idx == '0);

  // Segment byte and enable of the scanned digit
  assign scan_idx = ({1'b0, scan_position} < ssd_pkg::COUNT_W'(MAX_DIGITS)) ?
                    scan_position[IDX_W-1:0] : '0;

  always_comb begin
    glyph = ssd_pkg::glyph_of(digit_chars[scan_idx]);
    if (digit_blink[scan_idx] && blink_state) glyph = '0;
    mapped = '0;
    for (int m = 0; m < 8; m++) begin
      if (glyph[7-m]) mapped = mapped | (ssd_pkg::SEG_W'(1) << pin_map[21-3*m +: 3]);
    end
  end

  assign onehot               = ssd_pkg::EN_W'(1) << scan_position;
  assign display.segments     = invert ? ~mapped : mapped;
  assign display.digit_enable = invert ? onehot : ~onehot;
  assign display.blink_phase  = blink_state;

  // Configuration and display state
  always_ff @(posedge clk) begin
    if (rst) begin
      pin_map        <= ssd_pkg::PIN_MAP_RST;
      invert         <= 1'b0;
      digit_count    <= ssd_pkg::COUNT_RST;
      refresh_period <= ssd_pkg::REFRESH_RST;
      blink_period   <= ssd_pkg::BLINK_RST;
      for (int i = 0; i < MAX_DIGITS; i++) begin
        digit_chars[i] <= '0;
        digit_blink[i] <= 1'b0;
        saved_chars[i] <= '0;
        saved_blink[i] <= 1'b0;
      end
      scan_position <= '0;
      blink_state   <= 1'b0;
      refresh_count <= '0;
      blink_count   <= '0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          ssd_pkg::CFG_PIN_MAP:      pin_map        <= cfg_data[ssd_pkg::PIN_MAP_W-1:0];
          ssd_pkg::CFG_INVERT:       invert         <= cfg_data[0];
          ssd_pkg::CFG_DIGIT_COUNT:  digit_count    <= cfg_data[ssd_pkg::COUNT_W-1:0];
          ssd_pkg::CFG_REFRESH:      refresh_period <= cfg_data[ssd_pkg::PERIOD_W-1:0];
          ssd_pkg::CFG_BLINK_PERIOD: blink_period   <= cfg_data[ssd_pkg::PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        case (in_item.op)
          ssd_pkg::OP_TICK: begin
            if (refresh_hit) begin
              refresh_count <= '0;
              scan_position <= (scan_nx >= count_eff) ? '0 : scan_nx[ssd_pkg::POS_W-1:0];
            end else begin
              refresh_count <= refresh_nx[TIMER_BITS-1:0];
            end
            if (blink_hit) begin
              blink_count <= '0;
              blink_state <= ~blink_state;
            end else begin
              blink_count <= blink_nx[TIMER_BITS-1:0];
            end
          end
          ssd_pkg::OP_CHAR: begin
            if (pos_ok) digit_chars[pos_idx] <= in_item.char_code;
          end
          ssd_pkg::OP_BLINK: begin
            if (pos_ok) digit_blink[pos_idx] <= in_item.blink_flag;
          end
          ssd_pkg::OP_SAVE: begin
            saved_chars <= digit_chars;
            saved_blink <= digit_blink;
          end
          ssd_pkg::OP_RESTORE: begin
            digit_chars <= saved_chars;
            digit_blink <= saved_blink;
          end
          default: ;
        endcase
      end
      // Store one decimal digit per cycle, rightmost first
      if (cmd.conv_step) digit_chars[conv_idx] <= ssd_pkg::CHAR_ZERO + ssd_pkg::CHAR_W'(rem);
    end
  end

  // Conversion working registers and output register
  always_ff @(posedge clk) begin
    if (cmd.start && in_item.op == ssd_pkg::OP_NUMBER) begin
      num_reg  <= in_item.number;
      conv_idx <= conv_first;
    end else if (cmd.conv_step) begin
      num_reg  <= ssd_pkg::NUM_W'(quot);
      conv_idx <= conv_idx - IDX_W'(1);
    end
    if (cmd.load_out) out_item <= display;
  end

endmodule

// ===== rtl/seven_segment_scan_driver_top.sv =====
// Top level of the multiplexed seven-segment scan driver.
// Depends on ssd_pkg, ssd_ctrl and ssd_datapath.
`timescale 1ns / 1ps

// Each request returns one result: the segment byte and digit enable of the
// digit being scanned once the request has taken effect. Ticks, character and
// blink writes, save and restore go straight to the result stage; a number
// write first passes through conversion, where the datapath converts one
// decimal digit per cycle through a single divide-by-ten stage. The result
// sits in an output register, so the next request is taken while a result is
// still held; a further result waits until that register is free.
// Configuration is written through a plain write port, one register per write.
module seven_segment_scan_driver_top #(
  parameter int MAX_DIGITS = ssd_pkg::MAX_DIGITS_DEF,
  parameter int TIMER_BITS = ssd_pkg::TIMER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_enable,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ssd_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output ssd_pkg::out_item_t              out_item
);

  ssd_pkg::ssd_cmd_t    cmd;
  ssd_pkg::ssd_status_t status;

  // Request sequencing
  ssd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (in_item.op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Storage, timers and segment mapping
  ssd_datapath #(
    .MAX_DIGITS (MAX_DIGITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_item          (in_item),
    .out_item         (out_item),
    .cmd              (cmd),
    .status           (status)
  );

endmodule
